FILE: src/csag_pkg.sv
package csag_pkg;

    localparam int MAX_DIMENSION = 2048;
    localparam int DIM_W = $clog2(MAX_DIMENSION) + 1;
    localparam int IDX_W = DIM_W - 1;
    localparam int OFS_W = 22;
    localparam int DIV_STEPS = DIM_W;
    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W = 2;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = ((2 * OFS_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 2'd3;

    localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(320);
    localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(200);

    typedef struct packed {
        logic div_init;
        logic div_step;
        logic mul_load;
        logic fin;
    } csag_cmd_t;

    typedef struct packed {
        logic [DIM_W-1:0] sw;
        logic [DIM_W-1:0] sh;
        logic [DIM_W-1:0] tw;
        logic [DIM_W-1:0] th;
    } csag_dims_t;

    // A size of zero acts as one, and a size above the maximum is clamped.
    function automatic logic [DIM_W-1:0] effective(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > DIM_W'(MAX_DIMENSION))
        begin
            r = DIM_W'(MAX_DIMENSION);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

FILE: src/csag_ctrl.sv
module csag_ctrl
    import csag_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_start,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output csag_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             ovalid_reg;
    logic             ovalid_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_start)
                    begin
                        cmd.div_init = 1'b1;
                        cnt_next     = '0;
                        state_next   = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = ST_FIN;
            end
            ST_FIN:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.fin)
        begin
            ovalid_next = 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
        else
        begin
            ovalid_next = ovalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;

endmodule

FILE: src/csag_datapath.sv
module csag_datapath
    import csag_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  csag_cmd_t        cmd,
    input  csag_dims_t       dims,
    output logic [OFS_W-1:0] source_offset,
    output logic [OFS_W-1:0] target_offset,
    output logic             row_end,
    output logic             frame_end,
    output logic             row_repeat
);

    // The quotient registers first hold the dividends and shift them out
    // one bit per step; after the last step they hold the whole steps.
    logic [DIM_W-1:0] hq_reg;
    logic [DIM_W-1:0] hr_reg;
    logic [DIM_W-1:0] vq_reg;
    logic [DIM_W-1:0] vr_reg;
    logic [IDX_W-1:0] herr_reg;
    logic [IDX_W-1:0] verr_reg;
    logic [IDX_W-1:0] scol_reg;
    logic [OFS_W-1:0] srow_reg;
    logic [IDX_W-1:0] tcol_reg;
    logic [IDX_W-1:0] trow_reg;
    logic             rep_reg;
    logic [OFS_W-1:0] tprod_reg;
    logic [OFS_W-1:0] vprod_reg;

    logic [OFS_W-1:0] src_ofs_reg;
    logic [OFS_W-1:0] tgt_ofs_reg;
    logic             row_end_reg;
    logic             frame_end_reg;
    logic             row_rep_reg;

    logic [DIM_W:0]         h_trial;
    logic [DIM_W:0]         v_trial;
    logic                   h_ge;
    logic                   v_ge;
    logic [DIM_W:0]         h_rem_full;
    logic [DIM_W:0]         v_rem_full;
    logic [IDX_W+DIM_W-1:0] tprod_full;
    logic [2*DIM_W-1:0]     vprod_full;

    logic [DIM_W-1:0] col_inc;
    logic [DIM_W-1:0] row_inc;
    logic             row_end_c;
    logic             frame_end_c;
    logic [DIM_W-1:0] v_sum;
    logic             v_carry;
    logic [DIM_W-1:0] v_err_full;
    logic [DIM_W-1:0] h_sum;
    logic             h_carry;
    logic [DIM_W-1:0] h_err_full;
    logic [OFS_W-1:0] srow_next;
    logic [IDX_W-1:0] scol_next;

    always_comb
    begin
        h_trial    = {hr_reg, hq_reg[DIM_W-1]};
        v_trial    = {vr_reg, vq_reg[DIM_W-1]};
        h_ge       = h_trial >= {1'b0, dims.tw};
        v_ge       = v_trial >= {1'b0, dims.th};
        h_rem_full = h_ge ? h_trial - {1'b0, dims.tw} : h_trial;
        v_rem_full = v_ge ? v_trial - {1'b0, dims.th} : v_trial;
        tprod_full = trow_reg * dims.tw;
        vprod_full = vq_reg * dims.sw;
    end

    always_comb
    begin
        col_inc     = {1'b0, tcol_reg} + DIM_W'(1);
        row_inc     = {1'b0, trow_reg} + DIM_W'(1);
        row_end_c   = col_inc >= dims.tw;
        frame_end_c = row_end_c && (row_inc >= dims.th);

        v_sum      = {1'b0, verr_reg} + {1'b0, vr_reg[IDX_W-1:0]};
        v_carry    = v_sum >= dims.th;
        v_err_full = v_carry ? v_sum - dims.th : v_sum;
        srow_next  = srow_reg + vprod_reg + (v_carry ? OFS_W'(dims.sw) : '0);

        h_sum      = {1'b0, herr_reg} + {1'b0, hr_reg[IDX_W-1:0]};
        h_carry    = h_sum >= dims.tw;
        h_err_full = h_carry ? h_sum - dims.tw : h_sum;
        scol_next  = scol_reg + hq_reg[IDX_W-1:0] + IDX_W'(h_carry);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hq_reg   <= '0;
            hr_reg   <= '0;
            vq_reg   <= '0;
            vr_reg   <= '0;
            herr_reg <= '0;
            verr_reg <= '0;
            scol_reg <= '0;
            srow_reg <= '0;
            tcol_reg <= '0;
            trow_reg <= '0;
            rep_reg  <= 1'b0;
        end
        else if (cmd.div_init)
        begin
            hq_reg   <= dims.sw;
            hr_reg   <= '0;
            vq_reg   <= dims.sh;
            vr_reg   <= '0;
            herr_reg <= '0;
            verr_reg <= '0;
            scol_reg <= '0;
            srow_reg <= '0;
            tcol_reg <= '0;
            trow_reg <= '0;
            rep_reg  <= 1'b0;
        end
        else if (cmd.div_step)
        begin
            hq_reg <= {hq_reg[DIM_W-2:0], h_ge};
            vq_reg <= {vq_reg[DIM_W-2:0], v_ge};
            hr_reg <= h_rem_full[DIM_W-1:0];
            vr_reg <= v_rem_full[DIM_W-1:0];
        end
        else if (cmd.fin)
        begin
            if (frame_end_c)
            begin
                herr_reg <= '0;
                verr_reg <= '0;
                scol_reg <= '0;
                srow_reg <= '0;
                tcol_reg <= '0;
                trow_reg <= '0;
                rep_reg  <= 1'b0;
            end
            else if (row_end_c)
            begin
                tcol_reg <= '0;
                scol_reg <= '0;
                herr_reg <= '0;
                trow_reg <= row_inc[IDX_W-1:0];
                verr_reg <= v_err_full[IDX_W-1:0];
                srow_reg <= srow_next;
                rep_reg  <= (vq_reg == '0) && !v_carry;
            end
            else
            begin
                tcol_reg <= col_inc[IDX_W-1:0];
                scol_reg <= scol_next;
                herr_reg <= h_err_full[IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            tprod_reg <= OFS_W'(tprod_full);
            vprod_reg <= OFS_W'(vprod_full);
        end
        if (cmd.fin)
        begin
            src_ofs_reg   <= srow_reg + OFS_W'(scol_reg);
            tgt_ofs_reg   <= tprod_reg + OFS_W'(tcol_reg);
            row_end_reg   <= row_end_c;
            frame_end_reg <= frame_end_c;
            row_rep_reg   <= rep_reg;
        end
    end

    assign source_offset = src_ofs_reg;
    assign target_offset = tgt_ofs_reg;
    assign row_end       = row_end_reg;
    assign frame_end     = frame_end_reg;
    assign row_repeat    = row_rep_reg;

endmodule

FILE: src/coarse_image_scale_address_gen.sv
// Channel   Direction  tdata                                    tuser / tlast
// s_axis    in         [0] start_frame, rest zero               -
// m_axis    out        [21:0] source_offset, [43:22]            tuser [0] row_end,
//                      target_offset, rest zero                 [1] row_repeat;
//                                                               tlast frame_end
// cfg       in         cfg_we, cfg_index, cfg_data              -
//
// A pixel beat is taken in idle; the block then registers the two row multiplications,
// then forms the result in the output register and steps the state, and then returns to
// idle before the next beat is taken.
// A start beat first runs the bit-serial division of both axes side by side.
// One beat is in work at a time; a held result stalls only the final step.
// Reset clears the step state, so pixels before the first start read source offset zero.
module coarse_image_scale_address_gen
    import csag_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [0] start_frame
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // source_offset, target_offset
    output logic [M_TUSER_W-1:0] m_axis_tuser,   // row_end, row_repeat
    output logic                 m_axis_tlast,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    logic [DIM_W-1:0] sw_reg;
    logic [DIM_W-1:0] sh_reg;
    logic [DIM_W-1:0] tw_reg;
    logic [DIM_W-1:0] th_reg;
    csag_dims_t       dims;
    csag_cmd_t        cmd;
    logic [OFS_W-1:0] source_offset;
    logic [OFS_W-1:0] target_offset;
    logic             row_end;
    logic             frame_end;
    logic             row_repeat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg <= RESET_WIDTH;
            sh_reg <= RESET_HEIGHT;
            tw_reg <= RESET_WIDTH;
            th_reg <= RESET_HEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SOURCE_WIDTH:  sw_reg <= cfg_data;
                REG_SOURCE_HEIGHT: sh_reg <= cfg_data;
                REG_TARGET_WIDTH:  tw_reg <= cfg_data;
                REG_TARGET_HEIGHT: th_reg <= cfg_data;
                default:           sw_reg <= sw_reg;
            endcase
        end
    end

    always_comb
    begin
        dims.sw = effective(sw_reg);
        dims.sh = effective(sh_reg);
        dims.tw = effective(tw_reg);
        dims.th = effective(th_reg);
    end

    csag_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_start  (s_axis_tdata[0]),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    csag_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .dims          (dims),
        .source_offset (source_offset),
        .target_offset (target_offset),
        .row_end       (row_end),
        .frame_end     (frame_end),
        .row_repeat    (row_repeat)
    );

    assign m_axis_tdata = {{(M_TDATA_W - 2 * OFS_W){1'b0}}, target_offset, source_offset};
    assign m_axis_tuser = {row_repeat, row_end};
    assign m_axis_tlast = frame_end;

endmodule

FILE: src/csag_checker.sv
module csag_checker
    import csag_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [M_TUSER_W-1:0] m_axis_tuser,
    input logic                 m_axis_tlast
);

    // A held result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(m_axis_tvalid) |-> $past(m_axis_tready))
        else $error("output beat withdrawn without a handshake");

    // The frame's last pixel is also the last pixel of its row.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
        else $error("frame end without row end");

    // Only one beat is in work at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a beat is in work");

    // Target pixel zero lies on row zero, which never repeats a row.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[2*OFS_W-1:OFS_W] == '0) |-> !m_axis_tuser[1])
        else $error("row repeat flagged on the first row");

endmodule

bind coarse_image_scale_address_gen csag_checker u_csag_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

FILE: tb/testbench.sv
module testbench;
    import csag_pkg::*;

    typedef struct packed {
        logic [OFS_W-1:0] src;
        logic [OFS_W-1:0] tgt;
        logic             row_end;
        logic             frame_end;
        logic             rep;
    } pixel_addr_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;

    // Register copies and walk state of the address predictor.
    logic [11:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    logic [11:0] col_whole, row_whole;
    logic [10:0] col_rem, row_rem;
    logic [10:0] col_err, row_err, src_col, dst_col, dst_row;
    logic [21:0] row_base;
    logic        same_row;

    pixel_addr_t pending_pixels[$];
    pixel_addr_t got_pixel, want_pixel;
    int          mismatches;
    bit          steady;
    logic [CFG_IDX_W-1:0] size_regs [4];

    coarse_image_scale_address_gen uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int unsigned clamp_size(input logic [11:0] v);
        if (v == 12'd0)
        begin
            return 1;
        end
        if (v > 12'd2048)
        begin
            return 2048;
        end
        return v;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned pick_size(input int unsigned hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            return 0;
        end
        if (r < 8)
        begin
            return 4095;
        end
        if (r < 12)
        begin
            return 2048;
        end
        if (r < 18)
        begin
            return $urandom_range(1, 2048);
        end
        return $urandom_range(1, hi);
    endfunction

    task automatic restart_walk();
        col_err  = '0;
        row_err  = '0;
        src_col  = '0;
        row_base = '0;
        dst_col  = '0;
        dst_row  = '0;
        same_row = 1'b0;
    endtask

    task automatic predict_pixel(input bit start);
        int unsigned sw, sh, tw, th, acc, col;
        bit carry;
        pixel_addr_t p;
        sw = clamp_size(src_w_reg);
        sh = clamp_size(src_h_reg);
        tw = clamp_size(dst_w_reg);
        th = clamp_size(dst_h_reg);
        if (start)
        begin
            col_whole = 12'(sw / tw);
            col_rem   = 11'(sw % tw);
            row_whole = 12'(sh / th);
            row_rem   = 11'(sh % th);
            restart_walk();
        end
        p.row_end   = (dst_col + 32'd1 >= tw);
        p.frame_end = p.row_end && (dst_row + 32'd1 >= th);
        p.src       = row_base + 22'(src_col);
        p.tgt       = 22'(dst_row * tw + dst_col);
        p.rep       = same_row;
        pending_pixels.insert(pending_pixels.size(), p);

        if (p.frame_end)
        begin
            restart_walk();
        end
        else if (p.row_end)
        begin
            dst_col = '0;
            src_col = '0;
            col_err = '0;
            dst_row = dst_row + 11'd1;
            acc = row_err + row_rem;
            carry = (acc >= th);
            if (carry)
            begin
                acc = acc - th;
            end
            row_err  = 11'(acc);
            row_base = 22'(row_base + row_whole * sw + (carry ? sw : 0));
            same_row = (row_whole == 12'd0) && !carry;
        end
        else
        begin
            dst_col = dst_col + 11'd1;
            col = src_col + col_whole;
            acc = col_err + col_rem;
            if (acc >= tw)
            begin
                acc = acc - tw;
                col = col + 1;
            end
            col_err = 11'(acc);
            src_col = 11'(col);
        end
    endtask

    task automatic send_pixel(input bit start);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W-1){1'b0}}, start};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_pixel(start);
    endtask

    task automatic drain_pixels();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    // Leaves the write enable high; the caller lowers it after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= DIM_W'(v);
        @(posedge clk);
        case (idx)
            REG_SOURCE_WIDTH:  src_w_reg = 12'(v);
            REG_SOURCE_HEIGHT: src_h_reg = 12'(v);
            REG_TARGET_WIDTH:  dst_w_reg = 12'(v);
            REG_TARGET_HEIGHT: dst_h_reg = 12'(v);
            default: ;
        endcase
    endtask

    task automatic set_sizes(input int unsigned sw, input int unsigned sh,
                             input int unsigned tw, input int unsigned th);
        drain_pixels();
        write_reg(REG_SOURCE_WIDTH, sw);
        write_reg(REG_SOURCE_HEIGHT, sh);
        write_reg(REG_TARGET_WIDTH, tw);
        write_reg(REG_TARGET_HEIGHT, th);
        cfg_we <= 1'b0;
    endtask

    task automatic flag_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
        if (mismatches < 40)
        begin
            $display("%0t: %s expected %0d got %0d", $time, field, want, got);
        end
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_pixel.src       = m_axis_tdata[OFS_W-1:0];
            got_pixel.tgt       = m_axis_tdata[2*OFS_W-1:OFS_W];
            got_pixel.row_end   = m_axis_tuser[0];
            got_pixel.rep       = m_axis_tuser[1];
            got_pixel.frame_end = m_axis_tlast;
            if (pending_pixels.size() == 0)
            begin
                flag_mismatch("unexpected beat, source_offset", 0, got_pixel.src);
            end
            else
            begin
                want_pixel = pending_pixels.pop_front();
                if (got_pixel.src !== want_pixel.src)
                    flag_mismatch("source_offset", want_pixel.src, got_pixel.src);
                if (got_pixel.tgt !== want_pixel.tgt)
                    flag_mismatch("target_offset", want_pixel.tgt, got_pixel.tgt);
                if (got_pixel.row_end !== want_pixel.row_end)
                    flag_mismatch("row_end", want_pixel.row_end, got_pixel.row_end);
                if (got_pixel.frame_end !== want_pixel.frame_end)
                    flag_mismatch("frame_end", want_pixel.frame_end, got_pixel.frame_end);
                if (got_pixel.rep !== want_pixel.rep)
                    flag_mismatch("row_repeat", want_pixel.rep, got_pixel.rep);
            end
        end
    end

    initial
    begin
        int n;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            n = pick_gap();
            if (n > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // Before any start the step sizes are zero, so every beat reads source zero.
    task automatic test_no_start();
        repeat (4) send_pixel(1'b0);
    endtask

    task automatic test_unit_sizes();
        set_sizes(0, 1, 0, 1);
        send_pixel(1'b1);
        repeat (2) send_pixel(1'b0);
    endtask

    task automatic test_clamped_sizes();
        set_sizes(4095, 2048, 1, 2);
        send_pixel(1'b1);
        repeat (2) send_pixel(1'b0);
    endtask

    task automatic test_upscale_frame();
        set_sizes(3, 2, 4, 3);
        send_pixel(1'b1);
        repeat (12) send_pixel(1'b0);
    endtask

    task automatic test_random_frames();
        int sent, n, i;
        bit start;
        sent = 0;
        while (sent < 1500)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                drain_pixels();
                write_reg(size_regs[$urandom_range(0, 3)], pick_size(40));
                cfg_we <= 1'b0;
            end
            else
            begin
                set_sizes(pick_size(40), pick_size(40), pick_size(10), pick_size(10));
            end
            steady = ($urandom_range(0, 5) == 0);
            n = $urandom_range(20, 80);
            for (i = 0; i < n; i++)
            begin
                start = (i == 0 && $urandom_range(0, 4) != 0) || ($urandom_range(0, 39) == 0);
                if ($urandom_range(0, 29) == 0)
                begin
                    drain_pixels();
                end
                send_pixel(start);
            end
            sent += n;
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_index     = REG_SOURCE_WIDTH;
        cfg_data      = '0;
        steady        = 1'b0;
        mismatches    = 0;
        size_regs     = '{REG_SOURCE_WIDTH, REG_SOURCE_HEIGHT,
                          REG_TARGET_WIDTH, REG_TARGET_HEIGHT};
        src_w_reg     = 12'd320;
        src_h_reg     = 12'd200;
        dst_w_reg     = 12'd320;
        dst_h_reg     = 12'd200;
        col_whole     = '0;
        col_rem       = '0;
        row_whole     = '0;
        row_rem       = '0;
        restart_walk();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_no_start();
        test_unit_sizes();
        test_clamped_sizes();
        test_upscale_frame();
        test_random_frames();

        drain_pixels();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
